FILE: design/dfb_pkg.sv
// ----------------------------------------------------------------------------
// dfb_pkg: shared types and constants for the decimal fraction converter
// Weight tables, field widths and the control bundle between the top level
// and the accumulator.
// ----------------------------------------------------------------------------
package dfb_pkg;

  localparam int TABLE_LEN   = 20;
  localparam int IDX_W       = $clog2(TABLE_LEN);
  localparam int MAX_DIGITS_DEF = 20;
  localparam int DIGIT_W     = 4;
  localparam int SUM_W       = 64;
  localparam int GUARD_W     = 16;
  localparam int GFRAC_W     = 8;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [GUARD_W-1:0] guard_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // One item handed from the input register to the accumulator.
  typedef struct packed {
    logic   step;   // item consumed this cycle
    logic   last;   // terminator: finish, emit and clear
    digit_t digit;
  } dfb_ctrl_t;

  // Integer part of 2^64 / 10^(p+1).
  function automatic sum_t weight_main(input idx_t idx);
    sum_t w;
    unique case (idx)
      5'd0:    w = 64'h1999999999999999;
      5'd1:    w = 64'h028f5c28f5c28f5c;
      5'd2:    w = 64'h004189374bc6a7ef;
      5'd3:    w = 64'h00068db8bac710cb;
      5'd4:    w = 64'h0000a7c5ac471b47;
      5'd5:    w = 64'h000010c6f7a0b5ed;
      5'd6:    w = 64'h000001ad7f29abca;
      5'd7:    w = 64'h0000002af31dc461;
      5'd8:    w = 64'h000000044b82fa09;
      5'd9:    w = 64'h000000006df37f67;
      5'd10:   w = 64'h000000000afebff0;
      5'd11:   w = 64'h0000000001197998;
      5'd12:   w = 64'h00000000001c25c2;
      5'd13:   w = 64'h000000000002d093;
      5'd14:   w = 64'h000000000000480e;
      5'd15:   w = 64'h0000000000000734;
      5'd16:   w = 64'h00000000000000b8;
      5'd17:   w = 64'h0000000000000012;
      5'd18:   w = 64'h0000000000000001;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Next eight fraction bits of the same weight.
  function automatic logic [GFRAC_W-1:0] weight_guard(input idx_t idx);
    logic [GFRAC_W-1:0] g;
    unique case (idx)
      5'd0:    g = 8'h99;
      5'd1:    g = 8'h28;
      5'd2:    g = 8'h9d;
      5'd3:    g = 8'h29;
      5'd4:    g = 8'h84;
      5'd5:    g = 8'h8d;
      5'd6:    g = 8'hf4;
      5'd7:    g = 8'h18;
      5'd8:    g = 8'hb5;
      5'd9:    g = 8'h5e;
      5'd10:   g = 8'hbc;
      5'd11:   g = 8'h12;
      5'd12:   g = 8'h68;
      5'd13:   g = 8'h70;
      5'd14:   g = 8'hbe;
      5'd15:   g = 8'hac;
      5'd16:   g = 8'h77;
      5'd17:   g = 8'h72;
      5'd18:   g = 8'hd8;
      5'd19:   g = 8'h2f;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: design/dfb_if.sv
// ----------------------------------------------------------------------------
// dfb channel interfaces
// Valid/ready channels for digit beats and result beats.
// ----------------------------------------------------------------------------
interface dfb_digit_if import dfb_pkg::*; ();
  logic   valid;
  logic   ready;
  digit_t digit_value;
  logic   end_of_digits;

  modport source (output valid, output digit_value, output end_of_digits, input ready);
  modport sink   (input valid, input digit_value, input end_of_digits, output ready);
endinterface

interface dfb_frac_if import dfb_pkg::*; ();
  logic valid;
  logic ready;
  sum_t binary_fraction;

  modport source (output valid, output binary_fraction, input ready);
  modport sink   (input valid, input binary_fraction, output ready);
endinterface

FILE: design/dfb_accum.sv
// ----------------------------------------------------------------------------
// dfb_accum: weighted digit accumulator with round-to-nearest-even finish
// Holds digit position, main sum and guard sum; gives the rounded fraction
// for a terminator and clears on it.
// ----------------------------------------------------------------------------
module dfb_accum import dfb_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dfb_ctrl_t ctrl,
  output sum_t      result
);

  localparam int POS_W = $clog2(MAX_DIGITS + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  sum_t             main_r, main_nxt;
  guard_t           guard_r, guard_nxt;

  idx_t               idx;
  sum_t               w_main;
  logic [GFRAC_W-1:0] w_guard;
  sum_t               prod_main;
  guard_t             prod_guard;
  logic               take_digit;
  logic               sticky;
  logic               lsb;
  logic               rnd_inc;

  assign idx        = IDX_W'(pos_r);
  assign w_main     = weight_main(idx);
  assign w_guard    = weight_guard(idx);
  assign take_digit = ctrl.step && !ctrl.last && (pos_r < POS_W'(MAX_DIGITS));

  // digit times weight as four shifted copies
  always_comb begin
    prod_main = '0;
    for (int b = 0; b < DIGIT_W; b++) begin
      if (ctrl.digit[b]) begin
        prod_main = prod_main + (w_main << b);
      end
    end
  end

  assign prod_guard = GUARD_W'(ctrl.digit) * GUARD_W'(w_guard);

  // Round: half bit is guard[7], sticky the bits below, odd from the sum LSB.
  assign sticky  = |guard_r[GFRAC_W-2:0];
  assign lsb     = main_r[0] ^ guard_r[GFRAC_W];
  assign rnd_inc = guard_r[GFRAC_W-1] & (sticky | lsb);
  assign result  = main_r + SUM_W'(guard_r[GUARD_W-1:GFRAC_W]) + SUM_W'(rnd_inc);

  always_comb begin
    pos_nxt   = pos_r;
    main_nxt  = main_r;
    guard_nxt = guard_r;
    if (ctrl.step && ctrl.last) begin
      pos_nxt   = '0;
      main_nxt  = '0;
      guard_nxt = '0;
    end else if (take_digit) begin
      pos_nxt   = pos_r + POS_W'(1);
      main_nxt  = main_r + prod_main;
      guard_nxt = guard_r + prod_guard;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      main_r  <= '0;
      guard_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      main_r  <= main_nxt;
      guard_r <= guard_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_DIGITS))
    else $error("digit position past limit");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step && ctrl.last) |=> (pos_r == '0 && main_r == '0 && guard_r == '0))
    else $error("state not cleared after terminator");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step && !ctrl.last && pos_r == POS_W'(MAX_DIGITS)) |=> $stable(main_r))
    else $error("digit past limit changed the sum");

endmodule

FILE: design/decimal_fraction_to_binary.sv
// ----------------------------------------------------------------------------
// decimal_fraction_to_binary: decimal fraction digits to 0.64 binary fraction
// Digit beats in, most significant first; a terminator beat emits the
// rounded 64-bit fraction and clears the accumulated state.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; digit beats never stall, but a terminator
// waits while the output register holds a beat the sink has not taken.
// Path: the accept loads a terminator beat into the input register, then the
// accumulator/round result is loaded into the output register as the result beat.
// The sustained rate is set by the single digit-times-weight accumulate step.
// Reset (rst_n low, synchronous) empties both registers and clears position
// and sums to zero.
module decimal_fraction_to_binary import dfb_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dfb_digit_if.sink  in_chan,
  dfb_frac_if.source out_chan
);

  // input register
  logic   in_valid_r, in_valid_nxt;
  digit_t digit_r;
  logic   last_r;

  // result register
  logic   out_valid_r, out_valid_nxt;
  sum_t   frac_r;

  logic      in_take;
  logic      out_free;
  logic      s2_fire;
  dfb_ctrl_t ctrl;
  sum_t      result;

  // The output slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_chan.ready;
  // Digit beats never need the output slot; only a terminator waits on it.
  assign s2_fire  = in_valid_r && (!last_r || out_free);
  assign in_chan.ready = !in_valid_r || s2_fire;
  assign in_take  = in_chan.valid && in_chan.ready;

  assign ctrl.step  = s2_fire;
  assign ctrl.last  = last_r;
  assign ctrl.digit = digit_r;

  dfb_accum #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .result (result)
  );

  always_comb begin
    // refill the input register on a new beat, drop it once consumed
    priority if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (s2_fire) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end

    // load on a terminator, release when the sink takes the beat
    priority if (s2_fire && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_take) begin
      digit_r <= in_chan.digit_value;
      last_r  <= in_chan.end_of_digits;
    end
    if (s2_fire && last_r) begin
      frac_r <= result;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.binary_fraction = frac_r;

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && last_r) |=> out_valid_r)
    else $error("terminator consumed without a result beat");

  a_digit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && !last_r && !out_valid_r) |=> !out_valid_r)
    else $error("digit beat produced a result beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(s2_fire && last_r))
    else $error("pending result overwritten");

endmodule
